// ===== rtl/core/fdcd_pkg.sv =====
// Shared types, widths and constants for the frame difference change detector.
// No dependencies; imported by every module of the block but fdcd_ram.
`timescale 1ns / 1ps
`default_nettype none

package fdcd_pkg;

   localparam int unsigned MAX_REGION_PIXELS = 524288;
   localparam int unsigned MAX_FRAME_DIM     = 4096;

   localparam int unsigned ADDR_W   = $clog2(MAX_REGION_PIXELS);
   localparam int unsigned REGION_W = ADDR_W + 1;
   localparam int unsigned DIM_W    = 13;
   localparam int unsigned POS_W    = 12;
   localparam int unsigned PCT_W    = 7;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned PIXEL_W  = 3 * CHAN_W;
   localparam int unsigned DIV_W    = REGION_W + PCT_W;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = DIM_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROI_LEFT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROI_TOP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ROI_WIDTH    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ROI_HEIGHT   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PCT_LIMIT    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_RUNNING      = 3'd7;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [DIM_W-1:0] ROI_WIDTH_RESET    = 13'd640;
   localparam logic [DIM_W-1:0] ROI_HEIGHT_RESET   = 13'd480;
   localparam logic [PCT_W-1:0] PCT_LIMIT_RESET    = 7'd70;
   localparam logic [DIM_W-1:0] DIM_MAX            = DIM_W'(MAX_FRAME_DIM);
   localparam logic [REGION_W-1:0] REGION_LIMIT    = REGION_W'(MAX_REGION_PIXELS);

   localparam int unsigned GRAY_WEIGHT_W = 14;
   localparam int unsigned GRAY_PROD_W   = CHAN_W + GRAY_WEIGHT_W;
   localparam int unsigned GRAY_SUM_W    = GRAY_PROD_W + 1;
   localparam int unsigned GRAY_W        = GRAY_SUM_W - GRAY_WEIGHT_W;
   localparam logic [GRAY_WEIGHT_W-1:0] GRAY_WEIGHT_RED   = 14'd4899;
   localparam logic [GRAY_WEIGHT_W-1:0] GRAY_WEIGHT_GREEN = 14'd9617;
   localparam logic [GRAY_WEIGHT_W-1:0] GRAY_WEIGHT_BLUE  = 14'd1868;
   localparam logic [GRAY_SUM_W-1:0]    GRAY_ROUND        = 23'd8192;
   localparam logic [GRAY_W-1:0]        GRAY_LIMIT        = 9'd30;

   localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              frame_end;
   } req_word_type;

   typedef struct packed {
      logic [PCT_W-1:0] change_percent;
      logic             compared;
      logic             change_latched;
   } rsp_word_type;

   typedef struct packed {
      logic [DIM_W-1:0]    fw;
      logic [DIM_W-1:0]    fh;
      logic [POS_W-1:0]    left;
      logic [POS_W-1:0]    top;
      logic [DIM_W-1:0]    col_end;
      logic [DIM_W-1:0]    line_end;
      logic [REGION_W-1:0] area;
   } geom_type;

   typedef struct packed {
      logic latch;
      logic busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/fdcd_ram.sv =====
// Generic single-port synchronous RAM, read-first, with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fdcd_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr];
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fdcd_geom.sv =====
// Configuration registers and region geometry, with a serial divider for the
// height limit of the store. Depends on fdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdcd_geom import fdcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output geom_type               geom,
   output logic                   geom_ready,
   output logic [PCT_W-1:0]       limit,
   output logic                   running
);

   localparam int unsigned STEP_W   = $clog2(REGION_W + 2);
   localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(REGION_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(REGION_W + 1);
   localparam logic [STEP_W-1:0] BIT_TOP   = STEP_W'(REGION_W - 1);

   logic [DIM_W-1:0] frame_width_ff, frame_height_ff, roi_width_ff, roi_height_ff;
   logic [POS_W-1:0] roi_left_ff, roi_top_ff;
   logic [PCT_W-1:0] limit_ff;
   logic             running_ff;

   logic [STEP_W-1:0]   step_ff, step_in;
   logic                ready_ff, ready_in;
   logic [DIM_W-1:0]    rem_ff, rem_in;
   logic [REGION_W-1:0] quot_ff, quot_in;
   logic [DIM_W-1:0]    rh_ff, rh_in;
   geom_type            geom_ff, geom_in;

   logic [DIM_W-1:0]    fw, fh, rw0, rh0, span_w, span_h, rw, rh1;
   logic [POS_W-1:0]    left, top;
   logic [STEP_W-1:0]   bit_idx;
   logic [DIM_W:0]      rem_sh, rem_diff;
   logic [2*DIM_W-1:0]  area_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         roi_left_ff     <= '0;
         roi_top_ff      <= '0;
         roi_width_ff    <= ROI_WIDTH_RESET;
         roi_height_ff   <= ROI_HEIGHT_RESET;
         limit_ff        <= PCT_LIMIT_RESET;
         running_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
            REG_ROI_LEFT:     roi_left_ff     <= csr_data[POS_W-1:0];
            REG_ROI_TOP:      roi_top_ff      <= csr_data[POS_W-1:0];
            REG_ROI_WIDTH:    roi_width_ff    <= csr_data;
            REG_ROI_HEIGHT:   roi_height_ff   <= csr_data;
            REG_PCT_LIMIT:    limit_ff        <= csr_data[PCT_W-1:0];
            REG_RUNNING:      running_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fw = (frame_width_ff == '0) ? DIM_W'(1) :
           (frame_width_ff > DIM_MAX) ? DIM_MAX : frame_width_ff;
      fh = (frame_height_ff == '0) ? DIM_W'(1) :
           (frame_height_ff > DIM_MAX) ? DIM_MAX : frame_height_ff;
      left = ({1'b0, roi_left_ff} < fw) ? roi_left_ff : POS_W'(fw - DIM_W'(1));
      top  = ({1'b0, roi_top_ff} < fh) ? roi_top_ff : POS_W'(fh - DIM_W'(1));
      rw0    = (roi_width_ff == '0) ? DIM_W'(1) : roi_width_ff;
      rh0    = (roi_height_ff == '0) ? DIM_W'(1) : roi_height_ff;
      span_w = fw - {1'b0, left};
      span_h = fh - {1'b0, top};
      rw     = (rw0 > span_w) ? span_w : rw0;
      rh1    = (rh0 > span_h) ? span_h : rh0;
      bit_idx   = BIT_TOP - step_ff;
      rem_sh    = {rem_ff, REGION_LIMIT[bit_idx]};
      rem_diff  = rem_sh - {1'b0, rw};
      area_full = {{DIM_W{1'b0}}, rw} * {{DIM_W{1'b0}}, rh_ff};

      step_in  = step_ff;
      ready_in = ready_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      rh_in    = rh_ff;
      geom_in  = geom_ff;

      if (csr_write) begin
         step_in  = '0;
         ready_in = 1'b0;
         rem_in   = '0;
      end else if (!ready_ff) begin
         step_in = step_ff + STEP_W'(1);
         if (step_ff < STEP_MIN) begin
            if (rem_sh >= {1'b0, rw}) begin
               rem_in  = rem_diff[DIM_W-1:0];
               quot_in = {quot_ff[REGION_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[DIM_W-1:0];
               quot_in = {quot_ff[REGION_W-2:0], 1'b0};
            end
         end else if (step_ff == STEP_MIN) begin
            rh_in = ({{(REGION_W-DIM_W){1'b0}}, rh1} > quot_ff) ?
                    quot_ff[DIM_W-1:0] : rh1;
         end else begin
            geom_in.fw       = fw;
            geom_in.fh       = fh;
            geom_in.left     = left;
            geom_in.top      = top;
            geom_in.col_end  = {1'b0, left} + rw;
            geom_in.line_end = {1'b0, top} + rh_ff;
            geom_in.area     = area_full[REGION_W-1:0];
            ready_in         = (step_ff == STEP_LAST);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         ready_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         step_ff  <= step_in;
         ready_ff <= ready_in;
         rem_ff   <= rem_in;
      end
      quot_ff <= quot_in;
      rh_ff   <= rh_in;
      geom_ff <= geom_in;
   end

   assign geom       = geom_ff;
   assign geom_ready = ready_ff;
   assign limit      = limit_ff;
   assign running    = running_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fdcd_diff.sv =====
// Difference stage: absolute channel difference, weighted gray and threshold.
// Depends on fdcd_pkg; fed by the store read data.
`timescale 1ns / 1ps
`default_nettype none

module fdcd_diff import fdcd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmp_en,
   input  logic [PIXEL_W-1:0] cur_pixel,
   input  logic [PIXEL_W-1:0] prev_pixel,
   output logic               hit
);

   logic               en_ff, en_in;
   logic               hit_ff, hit_in;
   logic [PIXEL_W-1:0] cur_ff;

   logic [CHAN_W-1:0]      db, dg, dr;
   logic [GRAY_PROD_W-1:0] pb, pg, pr;
   logic [GRAY_SUM_W-1:0]  sum;
   logic [GRAY_W-1:0]      gray;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   always_comb begin
      db   = abs_diff(cur_ff[CHAN_W-1:0], prev_pixel[CHAN_W-1:0]);
      dg   = abs_diff(cur_ff[2*CHAN_W-1:CHAN_W], prev_pixel[2*CHAN_W-1:CHAN_W]);
      dr   = abs_diff(cur_ff[3*CHAN_W-1:2*CHAN_W], prev_pixel[3*CHAN_W-1:2*CHAN_W]);
      pb   = {{GRAY_WEIGHT_W{1'b0}}, db} * {{CHAN_W{1'b0}}, GRAY_WEIGHT_BLUE};
      pg   = {{GRAY_WEIGHT_W{1'b0}}, dg} * {{CHAN_W{1'b0}}, GRAY_WEIGHT_GREEN};
      pr   = {{GRAY_WEIGHT_W{1'b0}}, dr} * {{CHAN_W{1'b0}}, GRAY_WEIGHT_RED};
      sum  = {1'b0, pr} + {1'b0, pg} + {1'b0, pb} + GRAY_ROUND;
      gray = sum[GRAY_SUM_W-1:GRAY_WEIGHT_W];
      en_in  = cmp_en;
      hit_in = en_ff && (gray > GRAY_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         en_ff  <= en_in;
         hit_ff <= hit_in;
      end
      cur_ff <= cur_pixel;
   end

   assign hit = hit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fdcd_ctrl.sv =====
// Frame sequencer: raster counters, store addressing, changed count,
// percentage divider, change latch and result register. Depends on fdcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdcd_ctrl import fdcd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_data,
   input  geom_type           geom,
   input  logic               geom_ready,
   input  logic               cfg_write,
   input  logic [PCT_W-1:0]   limit,
   input  logic               running,
   output logic               ram_we,
   output logic [ADDR_W-1:0]  ram_addr,
   output logic [PIXEL_W-1:0] ram_wdata,
   output logic               cmp_en,
   input  logic               hit,
   output ctrl_status_type    status
);

   localparam logic [2:0] ST_RUN    = 3'd0;
   localparam logic [2:0] ST_DRAIN  = 3'd1;
   localparam logic [2:0] ST_SETTLE = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_POST   = 3'd5;

   localparam int unsigned QCNT_W = $clog2(PCT_W);
   localparam logic [QCNT_W-1:0] QCNT_TOP = QCNT_W'(PCT_W - 1);

   logic [2:0]          state_ff, state_in;
   logic [POS_W-1:0]    column_ff, column_in, line_ff, line_in;
   logic [REGION_W-1:0] region_ff, region_in;
   logic [REGION_W-1:0] changed_ff, changed_in;
   logic                overrun_ff, overrun_in;
   logic                prev_valid_ff, prev_valid_in;
   logic                latch_ff, latch_in;
   logic                cmp_frame_ff, cmp_frame_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [PCT_W-1:0]    quot_ff, quot_in;
   logic [QCNT_W-1:0]   qcnt_ff, qcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;

   logic                comparing, accept, in_region, slot_free, latch_next;
   logic [DIM_W-1:0]    column_inc, line_inc;
   logic [REGION_W-1:0] region_step;
   logic [DIV_W-1:0]    divisor_sh;
   logic [PCT_W-1:0]    pct;

   always_comb begin
      comparing  = prev_valid_ff && !latch_ff;
      req_stall  = !geom_ready || (state_ff != ST_RUN);
      accept     = req_valid && !req_stall;
      in_region  = !overrun_ff
                   && ({1'b0, column_ff} >= {1'b0, geom.left})
                   && ({1'b0, column_ff} < geom.col_end)
                   && ({1'b0, line_ff} >= {1'b0, geom.top})
                   && ({1'b0, line_ff} < geom.line_end)
                   && (region_ff < geom.area);
      ram_we     = accept && in_region;
      ram_addr   = region_ff[ADDR_W-1:0];
      ram_wdata  = {req_data.red, req_data.green, req_data.blue};
      cmp_en     = ram_we && comparing;
      column_inc = {1'b0, column_ff} + DIM_W'(1);
      line_inc   = {1'b0, line_ff} + DIM_W'(1);
      region_step = in_region ? region_ff + REGION_W'(1) : region_ff;
      divisor_sh = {{PCT_W{1'b0}}, geom.area} << qcnt_ff;
      slot_free  = !rsp_valid_ff || !rsp_stall;
      pct        = cmp_frame_ff ? quot_ff : '0;
      latch_next = latch_ff || (cmp_frame_ff && running && (pct >= limit));

      state_in      = state_ff;
      column_in     = column_ff;
      line_in       = line_ff;
      region_in     = region_ff;
      changed_in    = changed_ff + {{(REGION_W-1){1'b0}}, hit};
      overrun_in    = overrun_ff;
      prev_valid_in = prev_valid_ff;
      latch_in      = latch_ff;
      cmp_frame_in  = cmp_frame_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      qcnt_in       = qcnt_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               region_in = region_step;
               if (!overrun_ff) begin
                  if (column_inc >= geom.fw) begin
                     column_in = '0;
                     if (line_inc >= geom.fh) begin
                        overrun_in = 1'b1;
                     end else begin
                        line_in = line_inc[POS_W-1:0];
                     end
                  end else begin
                     column_in = column_inc[POS_W-1:0];
                  end
               end
               if (req_data.frame_end) begin
                  cmp_frame_in  = comparing;
                  prev_valid_in = (region_step == geom.area);
                  column_in     = '0;
                  line_in       = '0;
                  region_in     = '0;
                  overrun_in    = 1'b0;
                  state_in      = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rem_in     = {{PCT_W{1'b0}}, changed_ff} * {{REGION_W{1'b0}}, PCT_SCALE};
            changed_in = '0;
            qcnt_in    = QCNT_TOP;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= divisor_sh) begin
               rem_in  = rem_ff - divisor_sh;
               quot_in = {quot_ff[PCT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[PCT_W-2:0], 1'b0};
            end
            if (qcnt_ff == '0) begin
               state_in = ST_POST;
            end else begin
               qcnt_in = qcnt_ff - QCNT_W'(1);
            end
         end
         ST_POST: begin
            if (slot_free) begin
               latch_in                   = latch_next;
               rsp_data_in.change_percent = pct;
               rsp_data_in.compared       = cmp_frame_ff;
               rsp_data_in.change_latched = latch_next;
               rsp_valid_in               = 1'b1;
               state_in                   = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (cfg_write) begin
         prev_valid_in = 1'b0;
         column_in     = '0;
         line_in       = '0;
         region_in     = '0;
         changed_in    = '0;
         overrun_in    = 1'b0;
         state_in      = ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         column_ff     <= '0;
         line_ff       <= '0;
         region_ff     <= '0;
         changed_ff    <= '0;
         overrun_ff    <= 1'b0;
         prev_valid_ff <= 1'b0;
         latch_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         column_ff     <= column_in;
         line_ff       <= line_in;
         region_ff     <= region_in;
         changed_ff    <= changed_in;
         overrun_ff    <= overrun_in;
         prev_valid_ff <= prev_valid_in;
         latch_ff      <= latch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmp_frame_ff <= cmp_frame_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      qcnt_ff      <= qcnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign status.latch = latch_ff;
   assign status.busy  = (state_ff != ST_RUN);

endmodule

`default_nettype wire

// ===== rtl/core/frame_difference_change_detector.sv =====
// Frame difference change detector: top level with the previous-frame store.
// Depends on fdcd_pkg, fdcd_ram, fdcd_geom, fdcd_diff and fdcd_ctrl.
//
// Usage:
//   req channel: one BGR pixel word per accepted cycle, raster order, with
//   frame_end set on the last pixel of a frame. Words are accepted when
//   req_valid is high and req_stall is low.
//   rsp channel: one result word per frame, issued after the frame_end word;
//   held in an output register until taken (rsp_valid high, rsp_stall low).
//   csr port: write-only registers, one write per cycle with csr_write high.
// Throughput: one pixel per cycle within a frame. After a frame_end word
//   the input stalls while the store read and difference stages drain,
//   the bit-serial percentage divider runs and the result is loaded.
//   A result still waiting in the output register holds the next frame's
//   result at that last step. The single store port sets the pixel rate.
// Reset and configuration writes: the region geometry is recomputed by a
//   serial divider, stalling the input until it is done. The first frame after
//   either only fills the store; the change latch survives configuration.
`timescale 1ns / 1ps
`default_nettype none

module frame_difference_change_detector import fdcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   geom_type           geom;
   logic               geom_ready;
   logic [PCT_W-1:0]   limit;
   logic               running;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [PIXEL_W-1:0] ram_wdata;
   logic [PIXEL_W-1:0] ram_rdata;
   logic               cmp_en;
   logic               hit;
   ctrl_status_type    status;

   fdcd_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .geom       (geom),
      .geom_ready (geom_ready),
      .limit      (limit),
      .running    (running)
   );

   fdcd_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_REGION_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   fdcd_diff u_diff (
      .clock      (clock),
      .reset      (reset),
      .cmp_en     (cmp_en),
      .cur_pixel  (ram_wdata),
      .prev_pixel (ram_rdata),
      .hit        (hit)
   );

   fdcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .geom       (geom),
      .geom_ready (geom_ready),
      .cfg_write  (csr_write),
      .limit      (limit),
      .running    (running),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .cmp_en     (cmp_en),
      .hit        (hit),
      .status     (status)
   );

   a_store_addr_advances: assert property (@(posedge clock) disable iff (reset)
      ram_we && $past(ram_we) |-> ram_addr == $past(ram_addr) + 1'b1)
      else $error("store written out of sequence");

   a_latch_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(status.latch) |-> status.latch)
      else $error("change latch cleared without reset");

   a_stored_only_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.compared || rsp_data.change_percent == '0)
      else $error("non-zero percentage on a frame that was only stored");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && !req_stall))
      else $error("result issued while pixels were being accepted");

endmodule

`default_nettype wire
